// File: rtl/assert_macros.svh
// assertion macros shared by the color expand rtl
// no dependencies; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MBCE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("mbce assertion failed");
`define MBCE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbce assertion failed");
`define MBCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbce assertion failed");
`else
`define MBCE_ASSERT(lbl, clk, rst, prop)
`define MBCE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MBCE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/mbce_pkg.sv
// shared widths, register indexes, reset values and queue entry type
// for the monochrome bitmap color expand unit; no dependencies
package mbce_pkg;

   // default limits handed to the top level parameters
   localparam int DEF_MAX_SCREEN_DIM = 1024;
   localparam int DEF_MAX_GLYPH_DIM  = 256;

   // fixed field widths
   localparam int BYTE_BITS   = 8;
   localparam int MSB_INDEX   = 7;
   localparam int BYTE_W      = 8;
   localparam int SCR_REG_W   = 11;
   localparam int ORG_W       = 11;
   localparam int GLY_REG_W   = 9;
   localparam int COLOR_W     = 16;
   localparam int ADDR_W      = 20;
   localparam int POS_W       = 13;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   // largest values the dimension registers can hold
   localparam int SCR_REG_MAX = 2047;
   localparam int GLY_REG_MAX = 511;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GLYPH_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GLYPH_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INK_COLOR     = 3'd6;

   // register reset values
   localparam logic [SCR_REG_W-1:0] RST_SCREEN_DIM = 11'd1024;
   localparam logic [GLY_REG_W-1:0] RST_GLYPH_DIM  = 9'd8;
   localparam logic [COLOR_W-1:0]   RST_INK_COLOR  = 16'hFFFF;

   // one classified byte: visible pixel mask (bit b is icon pixel b from the left),
   // address of the screen row start, and screen column of the byte's first pixel
   typedef struct packed {
      logic [BYTE_BITS-1:0] mask;
      logic [ADDR_W-1:0]    row_base;
      logic [POS_W-1:0]     x0;
   } entry_type;

endpackage

// File: rtl/mbce_front.sv
// front end: configuration registers, icon row/column counters and per-byte clipping
// uses mbce_pkg and assert_macros.svh
`include "assert_macros.svh"

module mbce_front #(
   parameter int MAX_SCREEN_DIM = mbce_pkg::DEF_MAX_SCREEN_DIM,
   parameter int MAX_GLYPH_DIM  = mbce_pkg::DEF_MAX_GLYPH_DIM
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [mbce_pkg::BYTE_W-1:0]      req_bitmap_byte,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mbce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbce_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             q_full,
   output logic                             q_push,
   output mbce_pkg::entry_type              q_entry,
   output logic [mbce_pkg::COLOR_W-1:0]     ink_color
);
   import mbce_pkg::*;

   localparam int GLYPH_LIM = (MAX_GLYPH_DIM < GLY_REG_MAX) ? MAX_GLYPH_DIM : GLY_REG_MAX;
   localparam int SCR_LIM   = (MAX_SCREEN_DIM < SCR_REG_MAX) ? MAX_SCREEN_DIM : SCR_REG_MAX;
   localparam int GCNT_W    = $clog2(GLYPH_LIM + BYTE_BITS);
   localparam int SCR_W     = $clog2(SCR_LIM + 1);
   localparam int CMP_W     = GLY_REG_W + 1;
   localparam logic [GLY_REG_W-1:0] GLYPH_LIM_V = GLY_REG_W'(GLYPH_LIM);
   localparam logic [SCR_REG_W-1:0] SCR_LIM_V   = SCR_REG_W'(SCR_LIM);

   logic [SCR_REG_W-1:0] scr_w_ff, scr_w_in, scr_h_ff, scr_h_in;
   logic [ORG_W-1:0]     org_x_ff, org_x_in, org_y_ff, org_y_in;
   logic [GLY_REG_W-1:0] gly_w_ff, gly_w_in, gly_h_ff, gly_h_in;
   logic [COLOR_W-1:0]   ink_ff, ink_in;
   logic [GCNT_W-1:0]    colb_ff, colb_in, row_ff, row_in;

   logic                 csr_fire, cfg_hit, accept;
   logic [GLY_REG_W-1:0] gw_eff, gh_eff, rows;
   logic [SCR_REG_W-1:0] sw_eff, sh_eff;
   logic [CMP_W-1:0]     w_round, row_len, colb_next, row_next;
   logic                 col_wrap, row_wrap, row_ok;
   logic [POS_W-1:0]     py, x0;
   logic [BYTE_BITS-1:0] vis;
   logic [2*SCR_W-1:0]   prod;

   // configuration port, always ready
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign cfg_hit   = csr_fire && (csr_index <= REG_INK_COLOR);

   // register write decode
   always_comb begin
      scr_w_in = scr_w_ff;
      scr_h_in = scr_h_ff;
      org_x_in = org_x_ff;
      org_y_in = org_y_ff;
      gly_w_in = gly_w_ff;
      gly_h_in = gly_h_ff;
      ink_in   = ink_ff;
      if (csr_fire) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  scr_w_in = csr_data[SCR_REG_W-1:0];
            REG_SCREEN_HEIGHT: scr_h_in = csr_data[SCR_REG_W-1:0];
            REG_ORIGIN_X:      org_x_in = csr_data[ORG_W-1:0];
            REG_ORIGIN_Y:      org_y_in = csr_data[ORG_W-1:0];
            REG_GLYPH_WIDTH:   gly_w_in = csr_data[GLY_REG_W-1:0];
            REG_GLYPH_HEIGHT:  gly_h_in = csr_data[GLY_REG_W-1:0];
            REG_INK_COLOR:     ink_in   = csr_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp oversized dimensions
   assign gw_eff = (gly_w_ff > GLYPH_LIM_V) ? GLYPH_LIM_V : gly_w_ff;
   assign gh_eff = (gly_h_ff > GLYPH_LIM_V) ? GLYPH_LIM_V : gly_h_ff;
   assign sw_eff = (scr_w_ff > SCR_LIM_V) ? SCR_LIM_V : scr_w_ff;
   assign sh_eff = (scr_h_ff > SCR_LIM_V) ? SCR_LIM_V : scr_h_ff;

   // padded row length and row count; zero width gives one byte per row
   assign w_round = CMP_W'(gw_eff) + CMP_W'(MSB_INDEX);
   assign row_len = (gw_eff == '0) ? CMP_W'(BYTE_BITS) : {w_round[CMP_W-1:3], 3'b000};
   assign rows    = (gh_eff == '0) ? GLY_REG_W'(1) : gh_eff;

   // counter stepping
   assign accept    = req_push && !req_full;
   assign colb_next = CMP_W'(colb_ff) + CMP_W'(BYTE_BITS);
   assign col_wrap  = colb_next >= row_len;
   assign row_next  = CMP_W'(row_ff) + CMP_W'(1);
   assign row_wrap  = row_next >= CMP_W'(rows);

   always_comb begin
      colb_in = colb_ff;
      row_in  = row_ff;
      if (cfg_hit) begin
         colb_in = '0;
         row_in  = '0;
      end else if (accept) begin
         if (col_wrap) begin
            colb_in = '0;
            row_in  = row_wrap ? '0 : row_next[GCNT_W-1:0];
         end else begin
            colb_in = colb_next[GCNT_W-1:0];
         end
      end
   end

   // vertical clip for the current icon row
   assign py     = {{(POS_W-ORG_W){org_y_ff[ORG_W-1]}}, org_y_ff} + POS_W'(row_ff);
   assign row_ok = (CMP_W'(row_ff) < CMP_W'(gh_eff)) && !py[POS_W-1] &&
                   (py < POS_W'(sh_eff));

   // horizontal clip for each pixel of the byte
   assign x0 = {{(POS_W-ORG_W){org_x_ff[ORG_W-1]}}, org_x_ff} + POS_W'(colb_ff);

   for (genvar b = 0; b < BYTE_BITS; b++) begin : g_pix
      logic [POS_W-1:0] px;
      logic [CMP_W-1:0] col;
      assign px  = x0 + POS_W'(b);
      assign col = CMP_W'(colb_ff) + CMP_W'(b);
      assign vis[b] = req_bitmap_byte[MSB_INDEX-b] && (col < CMP_W'(gw_eff)) &&
                      !px[POS_W-1] && (px < POS_W'(sw_eff));
   end

   // row start address
   assign prod = (2*SCR_W)'(py[SCR_W-1:0]) * (2*SCR_W)'(sw_eff[SCR_W-1:0]);

   assign q_entry.mask     = row_ok ? vis : '0;
   assign q_entry.row_base = ADDR_W'(prod);
   assign q_entry.x0       = x0;
   assign q_push           = accept && (q_entry.mask != '0);
   assign req_full         = q_full;
   assign ink_color        = ink_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= RST_SCREEN_DIM;
         scr_h_ff <= RST_SCREEN_DIM;
         org_x_ff <= '0;
         org_y_ff <= '0;
         gly_w_ff <= RST_GLYPH_DIM;
         gly_h_ff <= RST_GLYPH_DIM;
         ink_ff   <= RST_INK_COLOR;
         colb_ff  <= '0;
         row_ff   <= '0;
      end else begin
         scr_w_ff <= scr_w_in;
         scr_h_ff <= scr_h_in;
         org_x_ff <= org_x_in;
         org_y_ff <= org_y_in;
         gly_w_ff <= gly_w_in;
         gly_h_ff <= gly_h_in;
         ink_ff   <= ink_in;
         colb_ff  <= colb_in;
         row_ff   <= row_in;
      end
   end

   // counters stay inside the icon
   `MBCE_ASSERT(a_col_in_row, clock, reset, CMP_W'(colb_ff) < row_len)
   `MBCE_ASSERT(a_row_in_icon, clock, reset, CMP_W'(row_ff) < CMP_W'(rows))

endmodule

// File: rtl/mbce_queue.sv
// short queue of classified bytes between front and back end
// uses mbce_pkg and assert_macros.svh
`include "assert_macros.svh"

module mbce_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mbce_pkg::entry_type entry_in,
   output logic                full,
   input  logic                pop,
   output mbce_pkg::entry_type head,
   output logic                empty
);
   import mbce_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   entry_type          store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // fill count bounded and consistent with traffic
   `MBCE_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH))
   `MBCE_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, count_ff != '0)
   `MBCE_ASSERT_NEXT(a_count_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

// File: rtl/mbce_back.sv
// back end: walks the visible pixel mask of each byte into a result register,
// one pixel write per cycle while that register is free; uses mbce_pkg
module mbce_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  mbce_pkg::entry_type           q_head,
   output logic                          q_pop,
   input  logic [mbce_pkg::COLOR_W-1:0]  ink_color,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [mbce_pkg::ADDR_W-1:0]   rsp_pixel_address,
   output logic [mbce_pkg::COLOR_W-1:0]  rsp_pixel_value,
   output logic                          rsp_last_of_byte
);
   import mbce_pkg::*;

   localparam int IDX_W = $clog2(BYTE_BITS);

   logic [BYTE_BITS-1:0] mask_ff, mask_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [POS_W-1:0]     x0_ff, x0_in;
   logic                 valid_ff, valid_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic                 last_ff, last_in;

   logic [IDX_W-1:0]     idx;
   logic [BYTE_BITS-1:0] rest, mask_after;
   logic                 out_free, emit;

   // leftmost pixel still to write
   always_comb begin
      idx = '0;
      for (int b = BYTE_BITS - 1; b >= 0; b--) begin
         if (mask_ff[b]) begin
            idx = IDX_W'(b);
         end
      end
   end

   assign out_free   = !valid_ff || rsp_pop;
   assign emit       = out_free && (mask_ff != '0);
   assign rest       = mask_ff & ~(BYTE_BITS'(1) << idx);
   assign mask_after = emit ? rest : mask_ff;
   assign q_pop      = (mask_after == '0) && !q_empty;

   // working byte: refill from the queue as soon as its last pixel goes out
   always_comb begin
      mask_in = mask_after;
      base_in = base_ff;
      x0_in   = x0_ff;
      if (q_pop) begin
         mask_in = q_head.mask;
         base_in = q_head.row_base;
         x0_in   = q_head.x0;
      end
   end

   // result register
   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      color_in = color_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         addr_in  = base_ff + ADDR_W'($signed(x0_ff)) + ADDR_W'(idx);
         color_in = ink_color;
         last_in  = (rest == '0);
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_pixel_value   = color_ff;
   assign rsp_last_of_byte  = last_ff;

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      x0_ff    <= x0_in;
      addr_ff  <= addr_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: rtl/mono_bitmap_color_expand_unit.sv
// top level of the monochrome bitmap color expand unit
// uses mbce_pkg, mbce_front, mbce_queue and mbce_back

// Expands a one-bit-per-pixel icon, fed as bytes (MSB is the leftmost pixel,
// rows padded to whole bytes), into 16-bit pixel writes at linear framebuffer
// addresses, clipped to the icon size and the screen. A byte is taken every
// cycle while the two-entry queue behind the front end has room; the front end
// clips the byte and finds its row address in the cycle it is taken, and bytes
// without a visible pixel leave no trace. The back end then gives one pixel
// write per cycle while the result port is drained, one per visible pixel of a
// byte, one to eight, so the result port limits the sustained rate. From idle,
// the first write of a byte passes the queue entry, the working byte and the
// result register. Registers are written through the csr port, which is always
// ready; any listed register write restarts the icon at its top left corner.
module mono_bitmap_color_expand_unit #(
   parameter int MAX_SCREEN_DIM = mbce_pkg::DEF_MAX_SCREEN_DIM,
   parameter int MAX_GLYPH_DIM  = mbce_pkg::DEF_MAX_GLYPH_DIM
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [mbce_pkg::BYTE_W-1:0]      req_bitmap_byte,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [mbce_pkg::ADDR_W-1:0]      rsp_pixel_address,
   output logic [mbce_pkg::COLOR_W-1:0]     rsp_pixel_value,
   output logic                             rsp_last_of_byte,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mbce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbce_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mbce_pkg::*;

   logic               q_full, q_push, q_pop, q_empty;
   entry_type          q_entry, q_head;
   logic [COLOR_W-1:0] ink_color;

   // byte intake, registers and clipping
   mbce_front #(
      .MAX_SCREEN_DIM (MAX_SCREEN_DIM),
      .MAX_GLYPH_DIM  (MAX_GLYPH_DIM)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_bitmap_byte (req_bitmap_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry),
      .ink_color       (ink_color)
   );

   // decoupling queue
   mbce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .entry_in (q_entry),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   // pixel write generation
   mbce_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .ink_color         (ink_color),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last_of_byte  (rsp_last_of_byte)
   );

endmodule
